>>> rtl/core/pms_pkg.sv
// pms_pkg: sizes, operation and status codes, and shared types of the
// partitioned multi-stack. No dependencies.
package pms_pkg;

  localparam int TOTAL_DEPTH = 16;
  localparam int NUM_STACKS  = 2;
  localparam int ITEM_WIDTH  = 32;

  localparam int SEG_DEPTH = TOTAL_DEPTH / NUM_STACKS;
  localparam int ADDR_W    = (TOTAL_DEPTH > 1) ? $clog2(TOTAL_DEPTH) : 1;
  localparam int CNT_W     = $clog2(SEG_DEPTH + 1);
  localparam int STK_W     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int STK_SLOTS = 1 << STK_W;

  // operation codes
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_LIST = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [ITEM_WIDTH-1:0] wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
  } mem_req_t;

  typedef struct packed {
    logic             en;
    logic [STK_W-1:0] idx;
    logic [CNT_W-1:0] val;
  } fill_upd_t;

endpackage

>>> rtl/core/pms_item_mem.sv
// pms_item_mem: shared item memory, one write and one registered read port.
// Depends on pms_pkg.
module pms_item_mem
  import pms_pkg::*;
(
  input  logic                  clk,
  input  mem_req_t              req,
  output logic [ITEM_WIDTH-1:0] rdata_r
);

  logic [ITEM_WIDTH-1:0] mem [TOTAL_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

endmodule

>>> rtl/core/pms_fill_regs.sv
// pms_fill_regs: per-stack fill counts, cleared by reset.
// Depends on pms_pkg.
module pms_fill_regs
  import pms_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [STK_W-1:0] rd_idx,
  output logic [CNT_W-1:0] rd_fill,
  input  fill_upd_t        upd
);

  logic [CNT_W-1:0] fill_r [STK_SLOTS];

  assign rd_fill = fill_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STK_SLOTS; i++) begin
        fill_r[i] <= '0;
      end
    end else if (upd.en) begin
      fill_r[upd.idx] <= upd.val;
    end
  end

endmodule

>>> rtl/core/partitioned_multi_stack.sv
// partitioned_multi_stack: sequencer and output register of the multi-stack.
// Depends on pms_pkg, pms_item_mem and pms_fill_regs.
//
// NUM_STACKS LIFO stacks share one item memory of TOTAL_DEPTH words, cut
// into equal segments of TOTAL_DEPTH/NUM_STACKS; stack s owns the segment
// starting at s*SEG_DEPTH. Each input word names an operation (push, pop,
// list) and a stack. Every operation gives one result word, except list,
// which gives one word per held item (bottom first, with a one-based
// position and last on the top item); operation code 3 is dropped with no
// result. Errors (full, empty, bad stack index) give a single word with
// item_value and item_position zero. Timing: push and all error cases load
// the output register in the accept cycle, and a new input word is taken in
// the same cycle the result drains, so these run at one word per cycle
// while out_ready stays high. Pop and each listed item need one synchronous
// memory read, registered in the memory and then loaded into the output
// register in state S_RD. One word is in flight at a time; the memory has no
// reset and needs no clearing pass.
module partitioned_multi_stack
  import pms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [1:0]  in_stack_index,
  input  logic [31:0] in_push_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_item_value,
  output logic [3:0]  out_item_position,
  output logic        out_last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;  // memory read in flight
  localparam logic [1:0] S_EMIT = 2'd2;  // result word held in output reg

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;     // items to list
  logic [CNT_W-1:0]  pos_r, pos_nxt;     // items listed so far
  logic              is_list_r, is_list_nxt;

  logic [1:0]        status_r, status_nxt;
  logic [31:0]       value_r, value_nxt;
  logic [CNT_W-1:0]  opos_r, opos_nxt;
  logic              last_r, last_nxt;

  logic                  acc;
  logic                  bad_idx;
  logic [STK_W-1:0]      stk;
  logic [CNT_W-1:0]      fill;
  logic [ADDR_W-1:0]     base;
  logic [CNT_W-1:0]      pos_inc;
  logic [ITEM_WIDTH-1:0] rdata;
  mem_req_t              mreq;
  fill_upd_t             fupd;

  pms_item_mem u_mem (
    .clk     (clk),
    .req     (mreq),
    .rdata_r (rdata)
  );

  pms_fill_regs u_fill (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (stk),
    .rd_fill (fill),
    .upd     (fupd)
  );

  assign in_ready = (state_r == S_IDLE) ||
                    ((state_r == S_EMIT) && out_ready && last_r);
  assign acc      = in_valid && in_ready;

  assign stk     = in_stack_index[STK_W-1:0];
  assign bad_idx = {1'b0, in_stack_index} >= 3'(NUM_STACKS);
  assign base    = ADDR_W'(ADDR_W'(stk) * ADDR_W'(SEG_DEPTH));
  assign pos_inc = pos_r + CNT_W'(1);

  assign out_valid         = (state_r == S_EMIT);
  assign out_status        = status_r;
  assign out_item_value    = value_r;
  assign out_item_position = 4'(opos_r);
  assign out_last          = last_r;

  always_comb begin
    state_nxt   = state_r;
    base_nxt    = base_r;
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    is_list_nxt = is_list_r;
    status_nxt  = status_r;
    value_nxt   = value_r;
    opos_nxt    = opos_r;
    last_nxt    = last_r;
    mreq        = '0;
    fupd        = '0;
    mreq.wdata  = ITEM_WIDTH'(in_push_value);
    fupd.idx    = stk;

    unique case (state_r)
      S_RD: begin
        // read data is valid now
        status_nxt = ST_OK;
        value_nxt  = 32'(rdata);
        if (is_list_r) begin
          opos_nxt = pos_inc;
          last_nxt = (pos_inc == cnt_r);
          pos_nxt  = pos_inc;
        end else begin
          opos_nxt = '0;
          last_nxt = 1'b1;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          if (!last_r) begin
            // next list item
            mreq.re    = 1'b1;
            mreq.raddr = base_r + ADDR_W'(pos_r);
            state_nxt  = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: ;
    endcase

    if (acc) begin
      status_nxt = ST_OK;
      value_nxt  = '0;
      opos_nxt   = '0;
      last_nxt   = 1'b1;
      if (in_operation != OP_PUSH && in_operation != OP_POP &&
          in_operation != OP_LIST) begin
        state_nxt = S_IDLE;
      end else if (bad_idx) begin
        status_nxt = ST_BAD;
        state_nxt  = S_EMIT;
      end else if (in_operation == OP_PUSH) begin
        if (fill >= CNT_W'(SEG_DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          mreq.we    = 1'b1;
          mreq.waddr = base + ADDR_W'(fill);
          fupd.en    = 1'b1;
          fupd.val   = fill + CNT_W'(1);
        end
        state_nxt = S_EMIT;
      end else if (fill == '0) begin
        status_nxt = ST_EMPTY;
        state_nxt  = S_EMIT;
      end else if (in_operation == OP_POP) begin
        mreq.re     = 1'b1;
        mreq.raddr  = base + ADDR_W'(fill - CNT_W'(1));
        fupd.en     = 1'b1;
        fupd.val    = fill - CNT_W'(1);
        is_list_nxt = 1'b0;
        state_nxt   = S_RD;
      end else begin
        mreq.re     = 1'b1;
        mreq.raddr  = base;
        base_nxt    = base;
        cnt_nxt     = fill;
        pos_nxt     = '0;
        is_list_nxt = 1'b1;
        state_nxt   = S_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r    <= base_nxt;
    cnt_r     <= cnt_nxt;
    pos_r     <= pos_nxt;
    is_list_r <= is_list_nxt;
    status_r  <= status_nxt;
    value_r   <= value_nxt;
    opos_r    <= opos_nxt;
    last_r    <= last_nxt;
  end

endmodule

>>> tb/sv/tb_top.sv
// tb_top: self-checking testbench for partitioned_multi_stack.
// Depends on pms_pkg and the partitioned_multi_stack RTL; holds its own stack
// predictor in a small scoreboard class, with plain tasks driving the ports.
module tb_top;
  import pms_pkg::*;

  // operation code 3 is dropped by the block and produces no result
  localparam logic [1:0] OP_IGNORED = 2'd3;

  localparam int RANDOM_WORDS     = 388;   // directed part adds about 22 more
  localparam int CALM_AFTER       = 350;   // no idling on either side after this
  localparam int HOLD_AT          = 150;   // long receiver hold-off starts here
  localparam int PAUSE_AT         = 280;   // sender waits for a full drain here
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int STALL_LIMIT      = 1000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES     = 40;    // wait after the final drain for stray words

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [3:0]  position;
    logic        last;
  } stack_result_t;

  // Stack predictor plus the queue of results still owed by the block.
  class stack_scoreboard;
    logic [ITEM_WIDTH-1:0] mem [TOTAL_DEPTH];
    int unsigned           depth [NUM_STACKS];
    stack_result_t         awaited [$];
    int unsigned           errors;

    function new();
      errors = 0;
      foreach (depth[s]) depth[s] = 0;
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    // Called on every accepted input word; queues what the block must return.
    function void note_word(logic [1:0] op, logic [1:0] idx, logic [31:0] val);
      stack_result_t r;
      int unsigned   base;
      int unsigned   n;
      r = '0;
      r.last = 1'b1;
      if (op == OP_IGNORED) return;
      if (idx >= NUM_STACKS) begin
        r.status = ST_BAD;
        awaited.push_back(r);
        return;
      end
      base = idx * SEG_DEPTH;
      n = depth[idx];
      case (op)
        OP_PUSH: begin
          if (n >= SEG_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            mem[base + n] = val[ITEM_WIDTH-1:0];
            depth[idx] = n + 1;
            r.status = ST_OK;
          end
          awaited.push_back(r);
        end
        OP_POP: begin
          if (n == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.status = ST_OK;
            r.value = 32'(mem[base + n - 1]);
            depth[idx] = n - 1;
          end
          awaited.push_back(r);
        end
        default: begin
          // list: bottom of the segment first, last flag on the top item
          if (n == 0) begin
            r.status = ST_EMPTY;
            awaited.push_back(r);
          end else begin
            for (int unsigned i = 0; i < n; i++) begin
              r.status = ST_OK;
              r.value = 32'(mem[base + i]);
              r.position = 4'(i + 1);
              r.last = (i + 1 == n);
              awaited.push_back(r);
            end
          end
        end
      endcase
    endfunction

    function void check_result(stack_result_t got);
      stack_result_t want;
      if (awaited.size() == 0) begin
        $error("result word with nothing pending: status %0d value 0x%08h", got.status,
               got.value);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.value !== want.value) begin
        $error("item_value: expected 0x%08h, got 0x%08h", want.value, got.value);
        errors++;
      end
      if (got.position !== want.position) begin
        $error("item_position: expected %0d, got %0d", want.position, got.position);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_operation;
  logic [1:0]  in_stack_index;
  logic [31:0] in_push_value;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_item_value;
  logic [3:0]  out_item_position;
  logic        out_last;

  stack_scoreboard sb;
  stack_result_t   seen_result;
  bit              calm;        // end of run: both sides stop idling
  bit              long_hold;   // request for one long receiver hold-off
  int unsigned     idle_cycles;

  partitioned_multi_stack u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_stack_index   (in_stack_index),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_item_value   (out_item_value),
    .out_item_position(out_item_position),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: everything is sampled at the rising edge. Results are checked
  // before the input word of the same edge is noted; the block never returns
  // a word in the cycle it accepts the input that causes it.
  // Also the watchdog: too many cycles without any handshake ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen_result.status   = out_status;
        seen_result.value    = out_item_value;
        seen_result.position = out_item_position;
        seen_result.last     = out_last;
        sb.check_result(seen_result);
      end
      if (in_valid && in_ready) begin
        sb.note_word(in_operation, in_stack_index, in_push_value);
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request,
  // and always ready once the run turns calm. Changes land on falling edges.
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      if (long_hold) begin
        // sender keeps offering words meanwhile, so the block backs up
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Offer one input word and hold it until accepted. Entered and left at a
  // falling edge; valid stays high on return so back-to-back words need no
  // second assignment in the same step.
  task automatic send_word(input logic [1:0] op, input logic [1:0] idx,
                           input logic [31:0] val);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_stack_index <= idx;
    in_push_value  <= val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed result word has come back.
  task automatic drain_all();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
  endtask

  initial begin
    int unsigned counted;
    int unsigned phase_left;
    int unsigned push_pct;
    int unsigned roll;
    int unsigned pick;
    int unsigned focus;
    logic [1:0]  op;
    logic [1:0]  idx;
    logic [31:0] val;
    bit          hold_done;
    bit          pause_done;

    sb             = new();
    calm           = 1'b0;
    long_hold      = 1'b0;
    idle_cycles    = 0;
    hold_done      = 1'b0;
    pause_done     = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_PUSH;
    in_stack_index = 2'd0;
    in_push_value  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part ----
    // empty cases on fresh stacks
    send_word(OP_LIST, 2'd0, 32'h0);
    send_word(OP_POP,  2'd1, 32'h0);
    // fill stack 0 to the end of its segment, extreme values first
    send_word(OP_PUSH, 2'd0, 32'h0000_0000);
    send_word(OP_PUSH, 2'd0, 32'hFFFF_FFFF);
    repeat (SEG_DEPTH - 2) send_word(OP_PUSH, 2'd0, $urandom);
    // push on a full stack, then a full-length list
    send_word(OP_PUSH, 2'd0, 32'h1234_5678);
    send_word(OP_LIST, 2'd0, 32'h0);
    send_word(OP_POP,  2'd0, 32'h0);
    // single-item list on stack 1, then pop it and hit empty again
    send_word(OP_PUSH, 2'd1, 32'hA5A5_5A5A);
    send_word(OP_LIST, 2'd1, 32'h0);
    send_word(OP_POP,  2'd1, 32'h0);
    send_word(OP_POP,  2'd1, 32'h0);
    send_word(OP_LIST, 2'd1, 32'h0);
    // stack numbers past the last stack, one per operation
    send_word(OP_PUSH, 2'(NUM_STACKS), 32'hDEAD_BEEF);
    send_word(OP_POP,  2'd3, 32'h0);
    send_word(OP_LIST, 2'd3, 32'h0);
    // code 3 gives nothing back
    send_word(OP_IGNORED, 2'd0, 32'hFFFF_FFFF);
    drain_all();

    // ---- random part ----
    // Phases pick a favored stack and a push share, so stacks swing between
    // full and empty; 8 percent are bad stack numbers and 4 percent dropped codes.
    counted    = 0;
    phase_left = 0;
    focus      = 0;
    push_pct   = 50;
    while (counted < RANDOM_WORDS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(15, 40);
        focus      = $urandom_range(0, NUM_STACKS - 1);
        case ($urandom_range(0, 2))
          0:       push_pct = 25;
          1:       push_pct = 55;
          default: push_pct = 85;
        endcase
      end
      phase_left--;

      val  = $urandom;
      pick = $urandom_range(0, 15);
      if (pick == 0) val = '0;
      else if (pick == 1) val = '1;

      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        op  = OP_IGNORED;
        idx = 2'($urandom_range(0, 3));
      end else begin
        if (roll < 12) idx = 2'($urandom_range(NUM_STACKS, 3));
        else if ($urandom_range(0, 9) < 7) idx = 2'(focus);
        else idx = 2'($urandom_range(0, NUM_STACKS - 1));
        pick = $urandom_range(0, 99);
        if (pick < push_pct) op = OP_PUSH;
        else if (pick < push_pct + (100 - push_pct) * 2 / 3) op = OP_POP;
        else op = OP_LIST;
        counted++;
      end

      if (counted >= HOLD_AT && !hold_done) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      if (counted >= PAUSE_AT && !pause_done) begin
        drain_all();
        pause_done = 1'b1;
      end
      if (counted >= CALM_AFTER) calm = 1'b1;

      send_word(op, idx, val);
    end

    // Wait for the last owed words, then give a dropped or stray word time
    // to show up before the verdict.
    drain_all();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
